### hdl/linear_array_deque_top_defines.svh
// Assertion macros for the linear array deque.
`ifndef LINEAR_ARRAY_DEQUE_TOP_DEFINES_SVH
`define LINEAR_ARRAY_DEQUE_TOP_DEFINES_SVH

// Consequent must hold in the cycle after the antecedent.
`define LDA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LDA_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### hdl/lda_pkg.sv
// Shared constants and types for the linear array deque.
`default_nettype none
package lda_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 16;

	localparam logic [1:0] OP_PUSH_REAR  = 2'd0;
	localparam logic [1:0] OP_PUSH_FRONT = 2'd1;
	localparam logic [1:0] OP_POP_FRONT  = 2'd2;
	localparam logic [1:0] OP_POP_REAR   = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_REAR_FULL = 2'd1;
	localparam logic [1:0] ST_FRONT_BEG = 2'd2;
	localparam logic [1:0] ST_EMPTY     = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic exec;
	} cmd_t;

	// datapath flags, read at the top level
	typedef struct packed {
		logic empty;
		logic rear_full;
	} stat_t;

endpackage
`default_nettype wire

### hdl/lda_ctrl.sv
// Request/response sequencer for the linear array deque.
`default_nettype none
module lda_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output lda_pkg::cmd_t    cmd,
	output logic             busy,
	output logic             done
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_RESP = 1'b1;

	logic state_q;
	logic state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.exec = start && (state_q == S_IDLE);
	assign busy     = (state_q == S_RESP);
	assign done     = (state_q == S_RESP);

endmodule
`default_nettype wire

### hdl/lda_dp.sv
// Store, pointers and result registers of the linear array deque.
`default_nettype none
module lda_dp #(
	parameter int DEPTH = lda_pkg::DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire lda_pkg::cmd_t                    cmd,
	input  wire logic [1:0]                       op,
	input  wire logic signed [lda_pkg::DATA_W-1:0] push_value,
	output lda_pkg::stat_t                        stat,
	output logic signed [lda_pkg::DATA_W-1:0]     pop_value,
	output logic [1:0]                            status
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_FULL = PW'(DEPTH);

	localparam logic [1:0] SEL_ZERO = 2'd0;
	localparam logic [1:0] SEL_NEG  = 2'd1;
	localparam logic [1:0] SEL_MEM  = 2'd2;

	logic [lda_pkg::DATA_W-1:0] mem [DEPTH];

	logic [PW-1:0]              front_q, rear_q;
	logic [PW-1:0]              front_d, rear_d;
	logic [PW-1:0]              front_m1, rear_m1;
	logic [1:0]                 status_q, status_d;
	logic [1:0]                 sel_q, sel_d;
	logic [lda_pkg::DATA_W-1:0] rdata_q;
	logic                       wr_en, rd_en;
	logic [AW-1:0]              addr;
	logic                       empty, rear_full;

	assign empty     = !(front_q < rear_q);
	assign rear_full = (rear_q == PTR_FULL);
	assign front_m1  = front_q - 1'b1;
	assign rear_m1   = rear_q - 1'b1;

	always_comb begin
		front_d  = front_q;
		rear_d   = rear_q;
		status_d = status_q;
		sel_d    = sel_q;
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		addr     = rear_q[AW-1:0];
		if (cmd.exec) begin
			status_d = lda_pkg::ST_OK;
			sel_d    = SEL_ZERO;
			case (op)
				lda_pkg::OP_PUSH_REAR: begin
					if (rear_full) begin
						status_d = lda_pkg::ST_REAR_FULL;
					end else begin
						wr_en  = 1'b1;
						addr   = rear_q[AW-1:0];
						rear_d = rear_q + 1'b1;
					end
				end
				lda_pkg::OP_PUSH_FRONT: begin
					if (front_q == '0) begin
						status_d = lda_pkg::ST_FRONT_BEG;
					end else if (rear_full) begin
						status_d = lda_pkg::ST_REAR_FULL;
					end else begin
						wr_en   = 1'b1;
						addr    = front_m1[AW-1:0];
						front_d = front_m1;
					end
				end
				lda_pkg::OP_POP_FRONT: begin
					if (empty) begin
						status_d = lda_pkg::ST_EMPTY;
						sel_d    = SEL_NEG;
					end else begin
						rd_en   = 1'b1;
						addr    = front_q[AW-1:0];
						front_d = front_q + 1'b1;
						sel_d   = SEL_MEM;
					end
				end
				lda_pkg::OP_POP_REAR: begin
					if (empty) begin
						status_d = lda_pkg::ST_EMPTY;
						sel_d    = SEL_NEG;
					end else begin
						rd_en  = 1'b1;
						addr   = rear_m1[AW-1:0];
						rear_d = rear_m1;
						sel_d  = SEL_MEM;
					end
				end
				default: begin
					status_d = lda_pkg::ST_OK;
				end
			endcase
		end
	end

	// single-port store: one write or one read per request
	always_ff @(posedge clk) begin
		if (wr_en) mem[addr] <= push_value;
		if (rd_en) rdata_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q  <= '0;
			rear_q   <= '0;
			status_q <= lda_pkg::ST_OK;
			sel_q    <= SEL_ZERO;
		end else begin
			front_q  <= front_d;
			rear_q   <= rear_d;
			status_q <= status_d;
			sel_q    <= sel_d;
		end
	end

	always_comb begin
		case (sel_q)
			SEL_MEM:  pop_value = rdata_q;
			SEL_NEG:  pop_value = '1;
			default:  pop_value = '0;
		endcase
	end

	assign status         = status_q;
	assign stat.empty     = empty;
	assign stat.rear_full = rear_full;

endmodule
`default_nettype wire

### hdl/linear_array_deque_top.sv
// Top level of the linear array deque: sequencer plus store datapath.
// A request taken at a clock edge (start high, busy low) is answered
// in the next cycle, with done high for exactly that one cycle.
// No new request is taken while a response is pending; busy stays high for the
// response cycle.
// Reset: arst_n clears both indices (queue empty) and the sequencer; the store
// itself is not cleared, so no clearing pass is needed. The receiver cannot stall.
`default_nettype none
`include "linear_array_deque_top_defines.svh"
module linear_array_deque_top #(
	parameter int DEPTH = lda_pkg::DEPTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [1:0]                        op,
	input  wire logic signed [lda_pkg::DATA_W-1:0] push_value,
	output logic                                   done,
	output logic signed [lda_pkg::DATA_W-1:0]      pop_value,
	output logic [1:0]                             status
);

	// Command from the sequencer: perform the transaction this cycle.
	lda_pkg::cmd_t  cmd;
	// Live flags of the queue, taken from the index registers.
	lda_pkg::stat_t stat;

	lda_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// Decide, update the indices and touch the store at the accepting edge;
	// hold the read word and status for the response cycle.
	lda_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.op         (op),
		.push_value (push_value),
		.stat       (stat),
		.pop_value  (pop_value),
		.status     (status)
	);

	// Every accepted transaction is answered in the very next cycle.
	`LDA_ASSERT_NEXT(a_resp_follows, clk, arst_n, cmd.exec, done, "no response after request")
	// A response only appears while new requests are held off.
	`LDA_ASSERT_SAME(a_done_busy, clk, arst_n, done, busy, "response while not busy")
	// A rear push that fits leaves the queue non-empty.
	`LDA_ASSERT_NEXT(a_push_fill, clk, arst_n, cmd.exec && (op == lda_pkg::OP_PUSH_REAR) && !stat.rear_full, !stat.empty, "queue empty after push")
	// An empty-queue answer always carries the all-ones word.
	`LDA_ASSERT_SAME(a_empty_word, clk, arst_n, done && (status == lda_pkg::ST_EMPTY), pop_value == -32'sd1, "empty pop without -1")

endmodule
`default_nettype wire
